// ===== src/rapq_pkg.sv =====
// Shared types and constants for the range-assign point-query tree.
package rapq_pkg;

  localparam int LEAVES_LG = 10;
  localparam int LEAVES    = 1 << LEAVES_LG;
  localparam int NODES     = 2 * LEAVES;
  localparam int NODE_W    = LEAVES_LG + 1;  // node address width
  localparam int SPAN_W    = NODE_W + 1;     // holds the open upper bound 2*LEAVES
  localparam int POS_W     = 10;
  localparam int DATA_W    = 32;

  localparam logic CMD_ASSIGN = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  localparam logic [DATA_W-1:0] STAMP_FULL = '1;

  typedef struct packed {
    logic [DATA_W-1:0]        stamp;
    logic signed [DATA_W-1:0] value;
  } node_t;

  typedef struct packed {
    logic                     cmd;
    logic [POS_W-1:0]         range_left;
    logic [POS_W-1:0]         range_right;
    logic signed [DATA_W-1:0] assign_value;
    logic [POS_W-1:0]         query_position;
  } item_t;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] read_value;
  } res_t;

endpackage

// ===== src/range_assign_point_query_tree.sv =====
// Top level of the range-assign point-query tree: stream ports and result register.
//
// Input stream (in_*): one transfer per item. in_tuser[0] is the command,
// 0 assigns assign_value to positions range_left..range_right (inclusive),
// 1 reads query_position. Output stream (out_*): exactly one transfer per item,
// read_value in out_tdata (0 for an assign) and status in out_tuser[0]
// (1 when an assign was dropped because the 32-bit stamp counter is full).
// Items are processed one at a time by a sequencer around a single node store
// (stamp and value per node, one write and one registered read per cycle).
// A query reads one node per tree level, 11 reads from leaf to root; it then drains
// the last read and closes out, and its result goes to the output register.
// An assign writes up to two nodes per level at one write per cycle; a dropped or
// empty assign writes nothing. The next item can be taken in the cycle after the
// result moves to the output register.
// After reset a clearing pass zeroes all 2048 nodes, one per cycle; in_tready
// stays low until the pass is done. A stalled receiver holds the result in the
// output register; the next item is still taken and waits finished in the
// sequencer until the register frees.
module range_assign_point_query_tree (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // range_left[9:0], range_right[19:10],
                                  // assign_value[51:20], query_position[61:52], zero pad
  input  logic [0:0]  in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_value[31:0]
  output logic [0:0]  out_tuser   // status[0]
);
  import rapq_pkg::*;

  item_t item;
  logic  res_valid;
  logic  res_ready;
  res_t  res;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_r;

  assign item.cmd            = in_tuser[0];
  assign item.range_left     = in_tdata[9:0];
  assign item.range_right    = in_tdata[19:10];
  assign item.assign_value   = in_tdata[51:20];
  assign item.query_position = in_tdata[61:52];

  rapq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // load when empty or when the held result leaves this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_r.read_value;
  assign out_tuser[0] = out_r.status;

`ifndef SYNTH
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_tvalid)
    else $error("finished result not loaded into output register");
`endif

endmodule

// ===== src/rapq_node_ram.sv =====
// Node store: stamp and value per tree node, one write and one registered read port.
module rapq_node_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [rapq_pkg::NODE_W-1:0] waddr,
  input  rapq_pkg::node_t            wdata,
  input  logic [rapq_pkg::NODE_W-1:0] raddr,
  output rapq_pkg::node_t            rdata
);
  import rapq_pkg::*;

  node_t mem [NODES];
  node_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rapq_seq.sv =====
// Sequencer: clearing pass, assign write sweep and query leaf-to-root read walk.
module rapq_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rapq_pkg::item_t in_item,
  output logic            res_valid,
  input  logic            res_ready,
  output rapq_pkg::res_t  res
);
  import rapq_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ASSIGN = 3'd2;
  localparam logic [2:0] S_QUERY  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [NODE_W-1:0] LAST_LEAF = NODE_W'(LEAVES - 1);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

  logic [2:0]               state_r, state_nxt;
  logic [NODE_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic [DATA_W-1:0]        stamp_r, stamp_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic [SPAN_W-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic [NODE_W-1:0]        k_r, k_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [DATA_W-1:0]        best_stamp_r, best_stamp_nxt;
  logic signed [DATA_W-1:0] best_val_r, best_val_nxt;
  res_t                     res_r, res_nxt;

  logic                     mem_we;
  logic [NODE_W-1:0]        mem_waddr;
  node_t                    mem_wdata;
  node_t                    mem_rdata;

  logic [NODE_W-1:0]        right_c;
  logic [SPAN_W-1:0]        lo_inc;
  logic [SPAN_W-1:0]        hi_dec;

  rapq_node_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (k_r),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  assign right_c = (NODE_W'(in_item.range_right) > LAST_LEAF) ? LAST_LEAF
                                                              : NODE_W'(in_item.range_right);
  assign lo_inc  = lo_r + SPAN_W'(1);
  assign hi_dec  = hi_r - SPAN_W'(1);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    stamp_nxt      = stamp_r;
    rd_pend_nxt    = 1'b0;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    k_nxt          = k_r;
    value_nxt      = value_r;
    best_stamp_nxt = best_stamp_r;
    best_val_nxt   = best_val_r;
    res_nxt        = res_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_addr_r;
    mem_wdata      = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + NODE_W'(1);
        if (clr_addr_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_nxt.status     = STATUS_OK;
          res_nxt.read_value = '0;
          if (in_item.cmd == CMD_QUERY) begin
            if (NODE_W'(in_item.query_position) > LAST_LEAF) begin
              state_nxt = S_DONE;
            end else begin
              k_nxt          = NODE_W'(in_item.query_position) + NODE_W'(LEAVES);
              best_stamp_nxt = '0;
              best_val_nxt   = '0;
              state_nxt      = S_QUERY;
            end
          end else if (stamp_r == STAMP_FULL) begin
            res_nxt.status = STATUS_DROPPED;
            state_nxt      = S_DONE;
          end else if (NODE_W'(in_item.range_left) > right_c) begin
            state_nxt = S_DONE;
          end else begin
            stamp_nxt = stamp_r + DATA_W'(1);
            lo_nxt    = SPAN_W'(in_item.range_left) + SPAN_W'(LEAVES);
            hi_nxt    = SPAN_W'(right_c) + SPAN_W'(LEAVES) + SPAN_W'(1);
            value_nxt = in_item.assign_value;
            state_nxt = S_ASSIGN;
          end
        end
      end
      S_ASSIGN: begin
        mem_wdata.stamp = stamp_r;
        mem_wdata.value = value_r;
        priority if (lo_r >= hi_r) begin
          state_nxt = S_DONE;
        end else if (lo_r[0]) begin
          // left border node; climb now unless the right border also needs a write
          mem_we    = 1'b1;
          mem_waddr = lo_r[NODE_W-1:0];
          if (hi_r[0]) begin
            lo_nxt = lo_inc;
          end else begin
            lo_nxt = lo_inc >> 1;
            hi_nxt = hi_r >> 1;
          end
        end else if (hi_r[0]) begin
          mem_we    = 1'b1;
          mem_waddr = hi_dec[NODE_W-1:0];
          lo_nxt    = lo_r >> 1;
          hi_nxt    = hi_dec >> 1;
        end else begin
          lo_nxt = lo_r >> 1;
          hi_nxt = hi_r >> 1;
        end
      end
      S_QUERY: begin
        // issue one read per level; data of the previous read arrives now
        if (k_r != '0) begin
          rd_pend_nxt = 1'b1;
          k_nxt       = k_r >> 1;
        end
        if (rd_pend_r && (mem_rdata.stamp > best_stamp_r)) begin
          best_stamp_nxt = mem_rdata.stamp;
          best_val_nxt   = mem_rdata.value;
        end
        if ((k_r == '0) && !rd_pend_r) begin
          res_nxt.read_value = best_val_r;
          state_nxt          = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      stamp_r    <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      stamp_r    <= stamp_nxt;
      rd_pend_r  <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    k_r          <= k_nxt;
    value_r      <= value_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_val_r   <= best_val_nxt;
    res_r        <= res_nxt;
  end

`ifndef SYNTH
  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QUERY || state_r == S_IDLE || state_r == S_DONE) |-> !mem_we)
    else $error("node store written outside clear or assign");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (stamp_r != $past(stamp_r))) |-> (stamp_r == $past(stamp_r) + DATA_W'(1)))
    else $error("stamp counter moved by other than one");

  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ASSIGN) |-> (lo_r <= hi_r))
    else $error("assign sweep bounds crossed");
`endif

endmodule

// ===== bench/range_assign_point_query_tree_tb.sv =====
// Self-checking testbench for the range-assign point-query tree: directed rows, then random traffic.
module range_assign_point_query_tree_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rapq_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_ITEMS   = 60;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_ROWS     = 32;
  localparam int MAX_PENDING  = 1024;

  typedef struct {
    item_t item;
    bit    known;
    res_t  want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // range_left[9:0], range_right[19:10],
                           // assign_value[51:20], query_position[61:52], zero pad
  logic [0:0]  in_tuser;   // cmd[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // read_value[31:0]
  logic [0:0]  out_tuser;  // status[0]

  // Mirror of the tree: stamp and value per node, plus the latest stamp handed out.
  logic [DATA_W-1:0] mirror_stamp [NODES];
  logic [DATA_W-1:0] mirror_value [NODES];
  logic [DATA_W-1:0] stamp_count;

  res_t pending_results [MAX_PENDING];
  int   pend_wr = 0;
  int   pend_rd = 0;
  row_t directed_rows [MAX_ROWS];
  int   row_count = 0;
  int   errors;
  int   cycle_count = 0;
  bit   calm;

  range_assign_point_query_tree DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic tree_assign(logic [POS_W-1:0] left, logic [POS_W-1:0] right,
                                       logic [DATA_W-1:0] value);
    int lo;
    int hi;
    int last;
    if (stamp_count == STAMP_FULL) return STATUS_DROPPED;
    last = (int'(right) > LEAVES - 1) ? LEAVES - 1 : int'(right);
    if (int'(left) > last) return STATUS_OK;
    stamp_count = stamp_count + 1;
    lo = int'(left) + LEAVES;
    hi = last + LEAVES + 1;
    // Walk the open interval [lo, hi) up the tree, stamping the canonical nodes.
    while (lo < hi) begin
      if (lo % 2 == 1) begin
        mirror_value[lo] = value;
        mirror_stamp[lo] = stamp_count;
        lo++;
      end
      if (hi % 2 == 1) begin
        hi--;
        mirror_value[hi] = value;
        mirror_stamp[hi] = stamp_count;
      end
      lo = lo / 2;
      hi = hi / 2;
    end
    return STATUS_OK;
  endfunction

  function automatic logic [DATA_W-1:0] tree_query(logic [POS_W-1:0] pos);
    int                k;
    logic [DATA_W-1:0] best_stamp;
    logic [DATA_W-1:0] best_value;
    best_stamp = '0;
    best_value = '0;
    if (int'(pos) >= LEAVES) return '0;
    for (k = int'(pos) + LEAVES; k != 0; k = k / 2) begin
      if (mirror_stamp[k] > best_stamp) begin
        best_stamp = mirror_stamp[k];
        best_value = mirror_value[k];
      end
    end
    return best_value;
  endfunction

  function automatic res_t predict_result(item_t it);
    res_t r;
    if (it.cmd == CMD_ASSIGN) begin
      r.read_value = '0;
      r.status     = tree_assign(it.range_left, it.range_right, it.assign_value);
    end else begin
      r.status     = STATUS_OK;
      r.read_value = tree_query(it.query_position);
    end
    return r;
  endfunction

  function automatic void add_row(logic cmd, int left, int right, logic [DATA_W-1:0] value,
                                  int pos, bit known, logic status,
                                  logic [DATA_W-1:0] read_value);
    row_t r;
    r.item.cmd            = cmd;
    r.item.range_left     = POS_W'(left);
    r.item.range_right    = POS_W'(right);
    r.item.assign_value   = value;
    r.item.query_position = POS_W'(pos);
    r.known               = known;
    r.want.status         = status;
    r.want.read_value     = read_value;
    directed_rows[row_count] = r;
    row_count++;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int clamp_pos(int p);
    if (p < 0) return 0;
    if (p > LEAVES - 1) return LEAVES - 1;
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    errors++;
  endtask

  // Present one item, hold it until the transfer, then record what it must produce.
  task automatic send_item(item_t it, bit known, res_t want);
    int   gap;
    res_t predicted;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {2'b00, it.query_position, it.assign_value, it.range_right, it.range_left};
    do @(posedge clk); while (in_tready !== 1'b1);
    predicted = predict_result(it);
    pending_results[pend_wr] = known ? want : predicted;
    pend_wr++;
  endtask

  // Receiver: random stall bursts, no new ones once the run turns calm.
  initial begin
    int stall;
    out_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        stall = $urandom_range(0, 8);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t head;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pend_rd == pend_wr) begin
        report_mismatch("result with nothing pending, read_value", out_tdata, '0);
      end else begin
        head = pending_results[pend_rd];
        pend_rd++;
        if (out_tdata !== head.read_value)
          report_mismatch("read_value", out_tdata, head.read_value);
        if (out_tuser[0] !== head.status)
          report_mismatch("status", 32'(out_tuser[0]), 32'(head.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    item_t it;
    res_t  none;
    int    sent;
    int    kind;
    int    left;
    int    right;
    int    a;
    int    b;
    int    probes;
    errors      = 0;
    calm        = 1'b0;
    none        = '0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    stamp_count = '0;
    for (int n = 0; n < NODES; n++) begin
      mirror_stamp[n] = '0;
      mirror_value[n] = '0;
    end

    // Untouched tree reads zero everywhere.
    add_row(CMD_QUERY,  1023, 1023, 32'hFFFF_FFFF,    0, 1, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,         1023, 1, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0, 1023, 32'h1234_5678,  512, 1, STATUS_OK, 32'h0);
    // Whole tree, then single leaves at both ends.
    add_row(CMD_ASSIGN,    0, 1023, 32'h7FFF_FFFF, 1023, 1, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,            0, 1, STATUS_OK, 32'h7FFF_FFFF);
    add_row(CMD_QUERY,     0,    0, 32'h0,         1023, 1, STATUS_OK, 32'h7FFF_FFFF);
    add_row(CMD_ASSIGN, 1023, 1023, 32'h8000_0000,    0, 1, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,         1023, 1, STATUS_OK, 32'h8000_0000);
    add_row(CMD_QUERY,     0,    0, 32'h0,         1022, 1, STATUS_OK, 32'h7FFF_FFFF);
    add_row(CMD_ASSIGN,    0,    0, 32'hFFFF_FFFF,  511, 1, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,            0, 1, STATUS_OK, 32'hFFFF_FFFF);
    // Empty ranges change nothing.
    add_row(CMD_ASSIGN,  700,  699, 32'h0000_0005,  700, 1, STATUS_OK, 32'h0);
    add_row(CMD_ASSIGN, 1023,    0, 32'hDEAD_BEEF,    0, 1, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,          700, 1, STATUS_OK, 32'h7FFF_FFFF);
    // Overlapping ranges: newer stamps win over older, wider ones.
    add_row(CMD_ASSIGN,    3, 1020, 32'h1234_5678,    0, 0, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,            2, 0, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,            3, 0, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,         1020, 0, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,         1021, 0, STATUS_OK, 32'h0);
    add_row(CMD_ASSIGN,  511,  512, 32'h0000_0000,  333, 0, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,   511,  512, 32'h0,          511, 0, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,          512, 0, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,          510, 0, STATUS_OK, 32'h0);
    add_row(CMD_QUERY,     0,    0, 32'h0,          513, 0, STATUS_OK, 32'h0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < row_count; i++)
      send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);

    // Random part: assign a range, then probe its edges, their outer neighbours and random positions with queries.
    // The stamp counter cannot fill up in a run of this length.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        left  = 0;
        right = LEAVES - 1;
      end else if (kind < 5) begin
        left  = $urandom_range(0, LEAVES - 1);
        right = clamp_pos(left + $urandom_range(0, 7));
      end else if (kind == 5) begin
        left  = $urandom_range(1, LEAVES - 1);
        right = $urandom_range(0, left - 1);
      end else begin
        a     = $urandom_range(0, LEAVES - 1);
        b     = $urandom_range(0, LEAVES - 1);
        left  = (a < b) ? a : b;
        right = (a < b) ? b : a;
      end
      it.cmd            = CMD_ASSIGN;
      it.range_left     = POS_W'(left);
      it.range_right    = POS_W'(right);
      it.assign_value   = pick_value();
      it.query_position = POS_W'($urandom);
      send_item(it, 1'b0, none);
      sent++;

      probes = $urandom_range(0, 3);
      repeat (probes) begin
        it.cmd          = CMD_QUERY;
        it.range_left   = POS_W'($urandom);
        it.range_right  = POS_W'($urandom);
        it.assign_value = $urandom;
        case ($urandom_range(0, 4))
          0:       it.query_position = POS_W'(clamp_pos(left - 1));
          1:       it.query_position = POS_W'(left);
          2:       it.query_position = POS_W'(right);
          3:       it.query_position = POS_W'(clamp_pos(right + 1));
          default: it.query_position = POS_W'($urandom);
        endcase
        send_item(it, 1'b0, none);
        sent++;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pend_rd != pend_wr) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
